// File: rtl/rgbc3_pkg.sv
// ----------------------------------------------------------------------------
// rgbc3_pkg
// Shared types and constants of the RGB 3x3 convolution filter: pixel and
// product formats, request and register codes, and the divide-by-9 constants.
// ----------------------------------------------------------------------------
package rgbc3_pkg;

    // Frame geometry defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_SIZE       = 1024;
    localparam int MIN_SIZE       = 3;
    localparam int SIZE_W         = 11;

    // Window and coefficient format
    localparam int WIN    = 3;
    localparam int PIX_W  = 8;
    localparam int COEF_W = 8;
    localparam int KROW_W = WIN * COEF_W;
    localparam logic [KROW_W-1:0] KERNEL_RESET = 24'h010101;

    // Configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Datapath widths: pixel x coefficient, row sum of three, sum of nine
    localparam int PROD_W = 16;
    localparam int ROW_W  = 18;
    localparam int SUM_W  = 20;
    localparam int MAG_W  = 19;

    // Divide by 9: q = (mag * RECIP) >> RECIP_SHIFT, exact for mag < 2^21
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP = 20'd932068;
    localparam int RECIP_SHIFT = 23;
    localparam int MULT_W      = MAG_W + RECIP_W;

    // Register stages inside the reduction unit
    localparam int REDUCE_STAGES = 4;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        prod_t blue;
        prod_t green;
        prod_t red;
    } prod3_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } cfg_index_t;

endpackage

// File: rtl/rgb_conv3x3_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter_top
// Streaming 3x3 convolution over an RGB raster frame, one request per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Requests are pixels in raster order or drain requests. The block takes one
// request every clock; it holds s_ready low only while a result sits in the
// output register and m_ready is low. The edge that accepts a request also
// starts the line store read; the following edges load the window cells,
// products, row sums, total, magnitude, reciprocal multiply and output
// register in turn. Results lag the pixel stream by image_width + 1 pixels;
// once the frame is complete, each drain request flushes one pending border
// result, and the last result of the frame carries frame_end. Interior
// pixels are the kernel-weighted window sum divided by 9 (toward zero), low
// 8 bits kept; border pixels pass unchanged. The two line stores are RAMs
// of MAX_WIDTH entries that are not cleared; every entry that reaches a
// result was written earlier in the same frame.
// Write configuration only while no result is pending.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter_top import rgbc3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PIX_W-1:0]     s_in_red,
    input  logic [PIX_W-1:0]     s_in_green,
    input  logic [PIX_W-1:0]     s_in_blue,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_out_red,
    output logic [PIX_W-1:0]     m_out_green,
    output logic [PIX_W-1:0]     m_out_blue,
    output logic                 m_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_RST  = (DEF_SIZE < MAX_WIDTH)  ? DEF_SIZE : MAX_WIDTH;
    localparam int HEIGHT_RST = (DEF_SIZE < MAX_HEIGHT) ? DEF_SIZE : MAX_HEIGHT;
    localparam int SIDE_DEPTH = 2 + REDUCE_STAGES;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
        rgb_t pass;
    } side_t;

    function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int hi);
        int v;
        v = int'(raw);
        if (v < MIN_SIZE) begin
            return MIN_SIZE;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Configuration registers
    logic [WW-1:0]     width_reg;
    logic [RW-1:0]     height_reg;
    logic [KROW_W-1:0] kernel_reg [WIN];

    // Position counters
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    // Request decode
    logic adv, accept, is_drain, complete, act, fill_done, emit, interior;
    logic sel_newer, a_last;
    rgb_t s_pix;

    // Line store stage
    logic          b_act_reg, b_emit_reg;
    logic          b_interior_reg, b_last_reg, b_sel_newer_reg;
    rgb_t          b_pix_reg;
    logic [CW-1:0] b_cidx_reg;
    logic          byp_a_reg, byp_b_reg;
    rgb_t          byp_old_reg, byp_new_reg;
    logic          wr_en;
    logic [$bits(rgb_t)-1:0] old_rd_a, old_rd_b, new_rd_a, new_rd_b;
    rgb_t          old_a, old_b, new_a, new_b, pass_pix;

    // Window and reduction
    rgb_t   row_in   [WIN];
    rgb_t   cell_pix [WIN][WIN];
    prod3_t cell_prod[WIN][WIN];
    prod_t  prod_red   [WIN][WIN];
    prod_t  prod_green [WIN][WIN];
    prod_t  prod_blue  [WIN][WIN];
    rgb_t   filt_pix;

    // Result side line and output register
    side_t side_reg [SIDE_DEPTH];
    logic  m_valid_reg;
    rgb_t  m_pix_reg;
    logic  m_last_reg;

    // The whole pipeline moves unless a result waits in the output register and m_ready is low
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign s_pix   = '{blue: s_in_blue, green: s_in_green, red: s_in_red};

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(WIDTH_RST);
            height_reg <= RW'(HEIGHT_RST);
            for (int i = 0; i < WIN; i++) begin
                kernel_reg[i] <= KERNEL_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    width_reg <= WW'(clamp_size(cfg_wdata[SIZE_W-1:0], MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg <= RW'(clamp_size(cfg_wdata[SIZE_W-1:0], MAX_HEIGHT));
                end
                CFG_KERNEL_TOP: begin
                    kernel_reg[0] <= cfg_wdata[KROW_W-1:0];
                end
                CFG_KERNEL_MIDDLE: begin
                    kernel_reg[1] <= cfg_wdata[KROW_W-1:0];
                end
                CFG_KERNEL_BOTTOM: begin
                    kernel_reg[2] <= cfg_wdata[KROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Decode the request against the frame position
    always_comb begin
        is_drain  = (s_req_type == REQ_DRAIN);
        complete  = 32'(in_row_reg) >= 32'(height_reg);
        act       = !is_drain && !complete;
        fill_done = (32'(in_row_reg) >= 32'd2)
                 || (32'(in_row_reg) == 32'd1 && 32'(in_col_reg) >= 32'd1);
        emit      = is_drain ? complete : (act && fill_done);
        interior  = !is_drain
                 && 32'(out_row_reg) >= 32'd1
                 && 32'(out_row_reg) + 32'd1 < 32'(height_reg)
                 && 32'(out_col_reg) >= 32'd1
                 && 32'(out_col_reg) + 32'd1 < 32'(width_reg);
        sel_newer = is_drain && (32'(out_row_reg) + 32'd1 >= 32'(height_reg));
    end

    // Advance the input and output positions; clear all at frame end
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        a_last       = 1'b0;
        if (act) begin
            if (32'(in_col_reg) + 32'd1 >= 32'(width_reg)) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (emit) begin
            if (32'(out_col_reg) + 32'd1 >= 32'(width_reg)) begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
            if (32'(out_row_next) >= 32'(height_reg)) begin
                a_last       = 1'b1;
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line stores: write at the stage after the read, forward on a collision
    assign wr_en = adv && b_act_reg;

    rgbc3_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (b_cidx_reg),
        .wdata   (new_a),
        .re      (accept),
        .raddr_a (in_col_reg),
        .raddr_b (out_col_reg),
        .rdata_a (old_rd_a),
        .rdata_b (old_rd_b)
    );

    rgbc3_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (b_cidx_reg),
        .wdata   (b_pix_reg),
        .re      (accept),
        .raddr_a (in_col_reg),
        .raddr_b (out_col_reg),
        .rdata_a (new_rd_a),
        .rdata_b (new_rd_b)
    );

    // Hold request control for the line store stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_act_reg  <= 1'b0;
            b_emit_reg <= 1'b0;
        end else if (adv) begin
            b_act_reg  <= accept && act;
            b_emit_reg <= accept && emit;
        end
    end

    // Hold request payload and the forwarding of the write in flight
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_interior_reg  <= interior;
            b_last_reg      <= a_last;
            b_sel_newer_reg <= sel_newer;
            b_pix_reg       <= s_pix;
            b_cidx_reg      <= in_col_reg;
            byp_a_reg       <= wr_en && (b_cidx_reg == in_col_reg);
            byp_b_reg       <= wr_en && (b_cidx_reg == out_col_reg);
            byp_old_reg     <= new_a;
            byp_new_reg     <= b_pix_reg;
        end
    end

    always_comb begin
        old_a    = byp_a_reg ? byp_old_reg : rgb_t'(old_rd_a);
        new_a    = byp_a_reg ? byp_new_reg : rgb_t'(new_rd_a);
        old_b    = byp_b_reg ? byp_old_reg : rgb_t'(old_rd_b);
        new_b    = byp_b_reg ? byp_new_reg : rgb_t'(new_rd_b);
        pass_pix = b_sel_newer_reg ? new_b : old_b;
    end

    assign row_in[0] = old_a;
    assign row_in[1] = new_a;
    assign row_in[2] = b_pix_reg;

    // Window: a chain of cells per kernel row, newest pixel enters at the right
    for (genvar r = 0; r < WIN; r++) begin : g_row
        for (genvar c = 0; c < WIN; c++) begin : g_col
            rgb_t cin;
            if (c == WIN - 1) begin : g_edge
                assign cin = row_in[r];
            end else begin : g_link
                assign cin = cell_pix[r][c+1];
            end

            rgbc3_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (wr_en),
                .prod_en  (adv),
                .pix_in   (cin),
                .coef     ($signed(kernel_reg[r][c*COEF_W +: COEF_W])),
                .pix_out  (cell_pix[r][c]),
                .prod     (cell_prod[r][c])
            );

            assign prod_red[r][c]   = cell_prod[r][c].red;
            assign prod_green[r][c] = cell_prod[r][c].green;
            assign prod_blue[r][c]  = cell_prod[r][c].blue;
        end
    end

    // Reduce each channel
    rgbc3_reduce u_reduce_red (
        .aclk (aclk),
        .en   (adv),
        .prod (prod_red),
        .res  (filt_pix.red)
    );

    rgbc3_reduce u_reduce_green (
        .aclk (aclk),
        .en   (adv),
        .prod (prod_green),
        .res  (filt_pix.green)
    );

    rgbc3_reduce u_reduce_blue (
        .aclk (aclk),
        .en   (adv),
        .prod (prod_blue),
        .res  (filt_pix.blue)
    );

    // Carry result control and pass-through pixel alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= '0;
            end
        end else if (adv) begin
            side_reg[0] <= '{emit: b_emit_reg, interior: b_interior_reg,
                             last: b_last_reg, pass: pass_pix};
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= side_reg[SIDE_DEPTH-1].emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pix_reg  <= side_reg[SIDE_DEPTH-1].interior ? filt_pix
                                                           : side_reg[SIDE_DEPTH-1].pass;
            m_last_reg <= side_reg[SIDE_DEPTH-1].last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg.red;
    assign m_out_green = m_pix_reg.green;
    assign m_out_blue  = m_pix_reg.blue;
    assign m_frame_end = m_last_reg;

    // The frame-end request returns every position counter to the origin
    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && a_last) |=> (in_col_reg == '0 && in_row_reg == '0
                                && out_col_reg == '0 && out_row_reg == '0))
        else $error("position counters not cleared after frame end");

    // A pixel after the frame is complete neither writes nor produces a result
    a_late_pixel_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_req_type && complete) |=> (!b_act_reg && !b_emit_reg))
        else $error("pixel after complete frame was not dropped");

    // A drain before the frame is complete is dropped
    a_early_drain_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type && !complete) |=> (!b_act_reg && !b_emit_reg))
        else $error("drain before complete frame was not dropped");

endmodule

// File: rtl/rgbc3_ram.sv
// ----------------------------------------------------------------------------
// rgbc3_ram
// Generic RAM with one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rgbc3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write, and read old data on an address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/rgbc3_cell.sv
// ----------------------------------------------------------------------------
// rgbc3_cell
// One window cell: holds one RGB pixel, hands it to its left neighbor on a
// shift, and registers the pixel times its kernel coefficient per channel.
// ----------------------------------------------------------------------------
module rgbc3_cell import rgbc3_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift_en,
    input  logic                     prod_en,
    input  rgb_t                     pix_in,
    input  logic signed [COEF_W-1:0] coef,
    output rgb_t                     pix_out,
    output prod3_t                   prod
);

    rgb_t   pix_reg;
    prod3_t prod_reg;

    function automatic prod_t mul_coef(input logic [PIX_W-1:0] p,
                                       input logic signed [COEF_W-1:0] k);
        logic signed [PIX_W+COEF_W:0] full;
        full = $signed({1'b0, p}) * k;
        return full[PROD_W-1:0];
    endfunction

    // Shift the held pixel in from the right neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else if (shift_en) begin
            pix_reg <= pix_in;
        end
    end

    // Register the weighted channels
    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg.red   <= mul_coef(pix_reg.red,   coef);
            prod_reg.green <= mul_coef(pix_reg.green, coef);
            prod_reg.blue  <= mul_coef(pix_reg.blue,  coef);
        end
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

// File: rtl/rgbc3_reduce.sv
// ----------------------------------------------------------------------------
// rgbc3_reduce
// Sums the nine weighted taps of one channel, divides by 9 truncating toward
// zero and gives the low 8 bits. Four register stages.
// ----------------------------------------------------------------------------
module rgbc3_reduce import rgbc3_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  prod_t            prod [WIN][WIN],
    output logic [PIX_W-1:0] res
);

    typedef logic signed [ROW_W-1:0] row_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    row_t               row_sum_reg  [WIN];
    row_t               row_sum_next [WIN];
    sum_t               total_reg;
    sum_t               total_next;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic               neg_d_reg;
    logic [PIX_W-1:0]   quot;

    // Add the three taps of each kernel row
    always_comb begin
        for (int r = 0; r < WIN; r++) begin
            row_sum_next[r] = '0;
            for (int c = 0; c < WIN; c++) begin
                row_sum_next[r] = row_sum_next[r] + ROW_W'(prod[r][c]);
            end
        end
    end

    // Add the row sums
    always_comb begin
        total_next = '0;
        for (int r = 0; r < WIN; r++) begin
            total_next = total_next + SUM_W'(row_sum_reg[r]);
        end
    end

    // Advance: row sums, total, magnitude, reciprocal product
    always_ff @(posedge aclk) begin
        if (en) begin
            row_sum_reg <= row_sum_next;
            total_reg   <= total_next;
            neg_reg     <= total_reg[SUM_W-1];
            mag_reg     <= total_reg[SUM_W-1] ? MAG_W'(-total_reg) : MAG_W'(total_reg);
            neg_d_reg   <= neg_reg;
            mult_reg    <= MULT_W'(mag_reg) * MULT_W'(RECIP);
        end
    end

    // Restore the sign on the kept low byte of the quotient
    assign quot = mult_reg[RECIP_SHIFT +: PIX_W];
    assign res  = neg_d_reg ? (~quot + PIX_W'(1)) : quot;

endmodule

// File: test/rgb_conv3x3_filter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter_top_tb
// Self-checking bench for the streaming RGB 3x3 convolution filter.
// ----------------------------------------------------------------------------
// A behavioral filter tracks the line stores, the 3x3 window and the frame
// position for each accepted request, and queues the pixel the block should
// return. The run starts with a hand-built 3x3 frame, then a wide frame and a
// tall frame under extreme kernels, and then random small frames with random
// kernels. Stray drain
// and pixel requests are mixed in. Idle and stall patterns vary by frame,
// and the bench includes one long receiver hold-off and one sender pause.
// Each result is compared field by field, in order, with the queue.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter_top_tb;
    import rgbc3_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int RANDOM_ITEMS   = 330;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_FRAME     = 4;
    localparam int PAUSE_FRAME    = 5;
    localparam int NUM_REGS       = int'(CFG_KERNEL_BOTTOM) + 1;
    localparam int LAST_REG_INDEX = (1 << CFG_IDX_W) - 1;
    localparam int RGB_W          = $bits(rgb_t);

    localparam logic [KROW_W-1:0] KERN_ZERO    = 24'h000000;
    localparam logic [KROW_W-1:0] KERN_MIN_ROW = 24'h808080;
    localparam logic [KROW_W-1:0] KERN_MAX_ROW = 24'h7F7F7F;
    localparam logic [KROW_W-1:0] KERN_NEG_ONE = 24'hFFFFFF;

    typedef struct {
        rgb_t pix;
        logic frame_end;
    } out_pixel_t;

    typedef struct {
        req_type_t  req;
        rgb_t       pix;
        bit         typed;
        out_pixel_t want;
    } dir_row_t;

    // DUT signals
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_req_type  = REQ_PIXEL;
    logic [PIX_W-1:0]     s_in_red    = '0;
    logic [PIX_W-1:0]     s_in_green  = '0;
    logic [PIX_W-1:0]     s_in_blue   = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [PIX_W-1:0]     m_out_red;
    logic [PIX_W-1:0]     m_out_green;
    logic [PIX_W-1:0]     m_out_blue;
    logic                 m_frame_end;

    // Filter state as the bench sees it
    rgb_t              older_row [DEF_MAX_WIDTH];
    rgb_t              newer_row [DEF_MAX_WIDTH];
    rgb_t              win [WIN][WIN];
    int                in_col, in_row, out_col, out_row;
    int                img_w, img_h;
    logic [KROW_W-1:0] kern [WIN];
    bit                frame_closed;
    out_pixel_t        queued_outputs [$];
    out_pixel_t        no_hand = '{pix: '0, frame_end: 1'b0};

    int err_cnt        = 0;
    int useful_cnt     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int send_pct_by_phase [4] = '{0, 73, 0, 11};
    int recv_pct_by_phase [4] = '{0, 0, 73, 11};

    // Hand-built 3x3 frame, all-ones kernel; border results typed in
    dir_row_t dir_rows [17] = '{
        '{REQ_DRAIN, 24'h000000, 1'b0, '{24'h000000, 1'b0}},  // frame not complete
        '{REQ_PIXEL, 24'h000000, 1'b0, '{24'h000000, 1'b0}},
        '{REQ_PIXEL, 24'hFFFFFF, 1'b0, '{24'h000000, 1'b0}},
        '{REQ_PIXEL, 24'h8000FF, 1'b0, '{24'h000000, 1'b0}},
        '{REQ_PIXEL, 24'h030201, 1'b0, '{24'h000000, 1'b0}},
        '{REQ_PIXEL, 24'hFFFFFF, 1'b1, '{24'h000000, 1'b0}},
        '{REQ_PIXEL, 24'h81807F, 1'b1, '{24'hFFFFFF, 1'b0}},
        '{REQ_DRAIN, 24'hFFFFFF, 1'b0, '{24'h000000, 1'b0}},  // frame not complete
        '{REQ_PIXEL, 24'hFFFFFF, 1'b1, '{24'h8000FF, 1'b0}},
        '{REQ_PIXEL, 24'h00FF00, 1'b1, '{24'h030201, 1'b0}},
        '{REQ_PIXEL, 24'hFFFFFF, 1'b0, '{24'h000000, 1'b0}},  // interior pixel
        '{REQ_PIXEL, 24'h123456, 1'b0, '{24'h000000, 1'b0}},  // frame already full
        '{REQ_DRAIN, 24'h000000, 1'b1, '{24'h81807F, 1'b0}},
        '{REQ_DRAIN, 24'h000000, 1'b1, '{24'hFFFFFF, 1'b0}},
        '{REQ_DRAIN, 24'h000000, 1'b1, '{24'h00FF00, 1'b0}},
        '{REQ_DRAIN, 24'h000000, 1'b1, '{24'hFFFFFF, 1'b1}},
        '{REQ_DRAIN, 24'h000000, 1'b0, '{24'h000000, 1'b0}}   // new frame, not complete
    };

    rgb_conv3x3_filter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_frame_end (m_frame_end)
    );

    always #CLK_HALF aclk = ~aclk;

    // Saturate a size register to MIN_SIZE..hi
    function automatic int clamp_side(logic [CFG_W-1:0] v, int hi);
        int s;
        s = int'(v[SIZE_W-1:0]);
        if (s < MIN_SIZE) return MIN_SIZE;
        if (s > hi) return hi;
        return s;
    endfunction

    function automatic void clear_position();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void filter_reset();
        img_w = clamp_side(CFG_W'(DEF_SIZE), DEF_MAX_WIDTH);
        img_h = clamp_side(CFG_W'(DEF_SIZE), DEF_MAX_HEIGHT);
        foreach (kern[i]) kern[i] = KERNEL_RESET;
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        clear_position();
        frame_closed = 1'b0;
    endfunction

    function automatic void filter_set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        case (idx)
            CFG_IMAGE_WIDTH:   img_w = clamp_side(v, DEF_MAX_WIDTH);
            CFG_IMAGE_HEIGHT:  img_h = clamp_side(v, DEF_MAX_HEIGHT);
            CFG_KERNEL_TOP:    kern[0] = v[KROW_W-1:0];
            CFG_KERNEL_MIDDLE: kern[1] = v[KROW_W-1:0];
            CFG_KERNEL_BOTTOM: kern[2] = v[KROW_W-1:0];
            default: ;
        endcase
    endfunction

    // Kernel-weighted window sum per channel, divided by 9 toward zero, low byte kept
    function automatic rgb_t convolve();
        logic [RGB_W-1:0] res;
        logic [RGB_W-1:0] px;
        int acc;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN; j++) begin
                    px = win[i][j];
                    acc += int'(px[PIX_W*ch +: PIX_W])
                         * int'($signed(kern[i][COEF_W*j +: COEF_W]));
                end
            end
            res[PIX_W*ch +: PIX_W] = PIX_W'(acc / (WIN * WIN));
        end
        return rgb_t'(res);
    endfunction

    // Queue one result pixel and advance the output position
    function automatic void queue_result(rgb_t px, bit typed, out_pixel_t hand);
        out_pixel_t o;
        o.pix       = px;
        o.frame_end = 1'b0;
        out_col++;
        if (out_col >= img_w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= img_h) begin
            o.frame_end  = 1'b1;
            frame_closed = 1'b1;
            clear_position();
        end
        queued_outputs.push_back(typed ? hand : o);
    endfunction

    // Apply one accepted request; return 0 when the block ignores it
    function automatic bit filter_step(req_type_t req, rgb_t pix, bit typed, out_pixel_t hand);
        bit   complete;
        bit   primed;
        bit   interior;
        int   oidx;
        int   cidx;
        rgb_t passthru;
        complete = in_row >= img_h;
        oidx = out_col < DEF_MAX_WIDTH ? out_col : DEF_MAX_WIDTH - 1;
        if (req == REQ_DRAIN) begin
            if (!complete) return 1'b0;
            queue_result(out_row + 1 >= img_h ? newer_row[oidx] : older_row[oidx], typed, hand);
            return 1'b1;
        end
        if (complete) return 1'b0;

        // Shift the window left and load the new column
        cidx = in_col < DEF_MAX_WIDTH ? in_col : DEF_MAX_WIDTH - 1;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j + 1];
        end
        win[0][WIN - 1] = older_row[cidx];
        win[1][WIN - 1] = newer_row[cidx];
        win[2][WIN - 1] = pix;

        passthru = older_row[oidx];
        primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
        older_row[cidx] = newer_row[cidx];
        newer_row[cidx] = pix;
        in_col++;
        if (in_col >= img_w) begin
            in_col = 0;
            in_row++;
        end

        if (primed) begin
            interior = out_row >= 1 && out_row + 1 < img_h
                    && out_col >= 1 && out_col + 1 < img_w;
            queue_result(interior ? convolve() : passthru, typed, hand);
        end
        return 1'b1;
    endfunction

    // Size register word with random bits above the size field
    function automatic logic [CFG_W-1:0] size_word(int side);
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom);
        v[SIZE_W-1:0] = SIZE_W'(side);
        return v;
    endfunction

    function automatic logic [KROW_W-1:0] pick_kernel();
        case ($urandom_range(7))
            0: return KERN_ZERO;
            1: return KERN_MIN_ROW;
            2: return KERN_MAX_ROW;
            3: return KERN_NEG_ONE;
            default: return KROW_W'($urandom);
        endcase
    endfunction

    // Write every register index, including the unused ones; call at a falling edge
    task automatic program_filter(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                  logic [KROW_W-1:0] k_top, logic [KROW_W-1:0] k_mid,
                                  logic [KROW_W-1:0] k_bot);
        logic [CFG_W-1:0] vals [NUM_REGS];
        logic [CFG_W-1:0] data;
        vals = '{w, h, CFG_W'(k_top), CFG_W'(k_mid), CFG_W'(k_bot)};
        for (int i = 0; i <= LAST_REG_INDEX; i++) begin
            if (i < NUM_REGS) data = vals[i];
            else data = CFG_W'($urandom);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= data;
            filter_set_reg(CFG_IDX_W'(i), data);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one request after a random gap and hold it until accepted
    task automatic offer(req_type_t req, rgb_t pix, bit typed, out_pixel_t hand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_in_red   <= pix.red;
        s_in_green <= pix.green;
        s_in_blue  <= pix.blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (filter_step(req, pix, typed, hand)) useful_cnt++;
        @(negedge aclk);
    endtask

    // Drop valid and let every queued result and any late request settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (queued_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One full frame of random pixels, then drains, with stray requests mixed in
    task automatic run_frame(int pause_at);
        int n;
        n = 0;
        frame_closed = 1'b0;
        while (in_row < img_h) begin
            if ($urandom_range(19) == 0) offer(REQ_DRAIN, rgb_t'(RGB_W'($urandom)), 1'b0, no_hand);
            if (n == pause_at) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (queued_outputs.size() != 0);
            end
            offer(REQ_PIXEL, rgb_t'(RGB_W'($urandom)), 1'b0, no_hand);
            n++;
        end
        while (!frame_closed) begin
            if ($urandom_range(19) == 0) offer(REQ_PIXEL, rgb_t'(RGB_W'($urandom)), 1'b0, no_hand);
            offer(REQ_DRAIN, rgb_t'(RGB_W'($urandom)), 1'b0, no_hand);
        end
        if ($urandom_range(3) == 0) offer(REQ_DRAIN, rgb_t'(RGB_W'($urandom)), 1'b0, no_hand);
    endtask

    // Result-side ready: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin : result_ready
        int hold_left;
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // Compare each accepted result with the oldest queued pixel
    always @(posedge aclk) begin : check_outputs
        out_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (queued_outputs.size() == 0) begin
                $error("result with none pending: %0h %0h %0h end=%0b",
                       m_out_red, m_out_green, m_out_blue, m_frame_end);
                err_cnt++;
            end else begin
                want = queued_outputs.pop_front();
                check_field("out_red",   want.pix.red,   m_out_red);
                check_field("out_green", want.pix.green, m_out_green);
                check_field("out_blue",  want.pix.blue,  m_out_blue);
                check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(m_frame_end));
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int frame_no;
        filter_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Hand-built frame; sizes written below the minimum saturate to 3x3
        program_filter(size_word(0), size_word(2), KERNEL_RESET, KERNEL_RESET, KERNEL_RESET);
        foreach (dir_rows[r]) offer(dir_rows[r].req, dir_rows[r].pix, dir_rows[r].typed,
                                    dir_rows[r].want);
        wait_idle();

        // Wide short frame, then a narrow tall one, under extreme kernels
        program_filter(size_word(40), size_word(1), KERN_MIN_ROW, KERN_MAX_ROW, KERN_NEG_ONE);
        run_frame(-1);
        wait_idle();
        program_filter(size_word(1), size_word(40), KERN_MAX_ROW, KERN_MIN_ROW, KERN_MAX_ROW);
        run_frame(-1);
        wait_idle();

        // Random small frames under rotating idle and stall patterns
        useful_cnt = 0;
        frame_no   = 0;
        while (useful_cnt < RANDOM_ITEMS || frame_no <= PAUSE_FRAME) begin
            send_idle_pct  = send_pct_by_phase[frame_no % 4];
            recv_stall_pct = recv_pct_by_phase[frame_no % 4];
            if (frame_no % 2 == 0 || frame_no == HOLD_FRAME) begin
                wait_idle();
                if (frame_no == HOLD_FRAME)
                    program_filter(size_word(10), size_word(6), pick_kernel(), pick_kernel(),
                                   pick_kernel());
                else
                    program_filter(size_word($urandom_range(10)), size_word($urandom_range(7)),
                                   pick_kernel(), pick_kernel(), pick_kernel());
            end
            // Hold the result side off so the block backs up into the request side
            if (frame_no == HOLD_FRAME) begin
                recv_stall_pct = 0;
                hold_len = HOLD_CYCLES;
            end
            run_frame(frame_no == PAUSE_FRAME ? img_w + 2 : -1);
            frame_no++;
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
